// ===== rtl/affine_warp_bilinear_defines.svh =====
// Assertion macros shared by the affine warp RTL.
// Depends on nothing; files that assert include it by name.
`ifndef AFFINE_WARP_BILINEAR_DEFINES_SVH
`define AFFINE_WARP_BILINEAR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define AW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define AW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aw_pkg.sv =====
// Shared types and constants for the affine warp block.
// Depends on nothing; every file but affine_warp_bilinear_defines.svh uses it.
package aw_pkg;

  localparam int SRC_ROWS_DEF = 256;
  localparam int SRC_COLS_DEF = 256;

  localparam int COORD_W   = 10;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  localparam int OPA_W  = 33;
  localparam int OPB_W  = 17;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 66;
  localparam int INT_W  = ACC_W - 2 * FRAC_W;
  localparam int DIFF_W = PIX_W + 1;
  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] MAP_LAST   = 3'd3;
  localparam logic [STEP_W-1:0] FETCH_LAST = 3'd4;
  localparam logic [STEP_W-1:0] BLEND_LAST = 3'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [CFG_W-1:0] COEF_ONE = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_00,
    REG_COEF_01,
    REG_COEF_02,
    REG_COEF_10,
    REG_COEF_11,
    REG_COEF_12,
    REG_SHIFT_X,
    REG_SHIFT_Y
  } aw_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_CHECK,
    S_FETCH,
    S_BLEND,
    S_RESULT
  } aw_state_t;

  typedef struct packed {
    logic en;
    logic load;
    logic shift16;
  } mac_op_t;

endpackage

// ===== rtl/aw_ifs.sv =====
// Valid/ready channel interfaces for input words, result words and register writes.
// Depends on aw_pkg for field widths.
interface aw_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [aw_pkg::COORD_W-1:0]     row;
  logic [aw_pkg::COORD_W-1:0]     col;
  logic [aw_pkg::PIX_W-1:0]       pixel_in;
  modport source(output valid, func, row, col, pixel_in, input ready);
  modport sink(input valid, func, row, col, pixel_in, output ready);
endinterface

interface aw_out_if;
  logic                           valid;
  logic                           ready;
  logic [aw_pkg::PIX_W-1:0]       pixel_out;
  logic                           in_bounds;
  modport source(output valid, pixel_out, in_bounds, input ready);
  modport sink(input valid, pixel_out, in_bounds, output ready);
endinterface

interface aw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aw_pkg::CFG_IDX_W-1:0]   index;
  logic [aw_pkg::CFG_W-1:0]       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/aw_mac.sv =====
// Shared signed multiply-accumulate unit with an optional 16-bit product shift.
// Depends on aw_pkg for operand widths and the operation struct.
module aw_mac (
  input  logic                              clk,
  input  aw_pkg::mac_op_t                   op,
  input  logic signed [aw_pkg::OPA_W-1:0]   a,
  input  logic signed [aw_pkg::OPB_W-1:0]   b,
  input  logic signed [aw_pkg::ACC_W-1:0]   base,
  output logic signed [aw_pkg::ACC_W-1:0]   acc
);
  import aw_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  sum;

  always_comb begin
    prod     = $signed({{(PROD_W-OPA_W){a[OPA_W-1]}}, a})
             * $signed({{(PROD_W-OPB_W){b[OPB_W-1]}}, b});
    prod_ext = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
    addend   = op.shift16 ? (prod_ext <<< FRAC_W) : prod_ext;
    sum      = (op.load ? base : acc) + addend;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= sum;
    end
  end

endmodule

// ===== rtl/aw_img_mem.sv =====
// Single-port source image memory with registered read data.
// Depends on aw_pkg for the pixel width.
module aw_img_mem #(
  parameter int ADDR_W = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [aw_pkg::PIX_W-1:0]   wdata,
  output logic [aw_pkg::PIX_W-1:0]   rdata
);
  import aw_pkg::*;

  logic [PIX_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/affine_warp_bilinear.sv =====
// Top level of the affine warp: register file, sequencer, shared MAC and image memory.
// Depends on aw_pkg, aw_ifs, aw_mac, aw_img_mem and affine_warp_bilinear_defines.svh.
//
//   channel  dir  word
//   in_ch    in   func, row, col, pixel_in
//   out_ch   out  pixel_out, in_bounds
//   cfg      in   index, data (always ready)
//
// A request maps its source point with eight passes of the shared 33x17 multiply-accumulate;
// when the point and all its neighbors lie inside the image, four reads of the single-port
// image memory fetch the neighbors and three more passes blend them. Reset is synchronous and
// restores the identity matrix; image contents are undefined until written. A stalled
// result waits in the output register while the next word is taken.
`include "affine_warp_bilinear_defines.svh"

module affine_warp_bilinear #(
  parameter int SRC_ROWS = aw_pkg::SRC_ROWS_DEF,
  parameter int SRC_COLS = aw_pkg::SRC_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  aw_in_if.sink      in_ch,
  aw_out_if.source   out_ch,
  aw_cfg_if.sink     cfg
);
  import aw_pkg::*;

  localparam int ROW_W  = $clog2(SRC_ROWS);
  localparam int COL_W  = $clog2(SRC_COLS);
  localparam int ADDR_W = ROW_W + COL_W;

  logic [CFG_W-1:0] coef_00, coef_01, coef_02, coef_10, coef_11, coef_12;
  logic [CFG_W-1:0] shift_x, shift_y;

  aw_state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  logic in_fire, out_free, out_valid;
  logic [PIX_W-1:0] out_pix;
  logic out_inb;

  logic signed [OPA_W-1:0] u, v, u_next, v_next;

  logic x_neg, x_ge, x_last;
  logic [ROW_W-1:0] x_idx;
  logic [COL_W-1:0] y_idx;
  logic [FRAC_W-1:0] fx, fy;

  logic acc_neg;
  logic [INT_W-1:0] acc_int;
  logic y_ge_now, y_last_now, stop_now;

  logic [PIX_W-1:0] pix [4];
  logic [1:0] pix_sel;
  logic [PIX_W-1:0] bottom, res_pix;
  logic res_inb;

  logic signed [DIFF_W-1:0] d_bot, d_top, d_fin;
  logic [CFG_W-1:0] map_a0, map_a1, map_c;

  mac_op_t mac_op;
  logic signed [OPA_W-1:0] mac_a;
  logic signed [OPB_W-1:0] mac_b;
  logic signed [ACC_W-1:0] mac_base, acc;

  logic mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0] mem_rdata;
  logic row_ok, col_ok;

  aw_mac u_mac (
    .clk  (clk),
    .op   (mac_op),
    .a    (mac_a),
    .b    (mac_b),
    .base (mac_base),
    .acc  (acc)
  );

  aw_img_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_ch.pixel_in),
    .rdata (mem_rdata)
  );

  assign cfg.ready = 1'b1;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.pixel_out = out_pix;
  assign out_ch.in_bounds = out_inb;

  assign u_next = $signed({{(OPA_W-COORD_W-FRAC_W){1'b0}}, in_ch.row, {FRAC_W{1'b0}}})
                - $signed({shift_y[CFG_W-1], shift_y});
  assign v_next = $signed({{(OPA_W-COORD_W-FRAC_W){1'b0}}, in_ch.col, {FRAC_W{1'b0}}})
                - $signed({shift_x[CFG_W-1], shift_x});

  assign row_ok = {1'b0, in_ch.row} < (COORD_W+1)'(SRC_ROWS);
  assign col_ok = {1'b0, in_ch.col} < (COORD_W+1)'(SRC_COLS);

  assign acc_neg    = acc[ACC_W-1];
  assign acc_int    = acc[ACC_W-1:2*FRAC_W];
  assign y_ge_now   = acc_int >= INT_W'(SRC_COLS);
  assign y_last_now = acc_int >= INT_W'(SRC_COLS - 1);
  assign stop_now   = x_neg || x_ge || x_last || acc_neg || y_ge_now || y_last_now;

  assign map_a0 = (state == S_MAPY) ? coef_10 : coef_00;
  assign map_a1 = (state == S_MAPY) ? coef_11 : coef_01;
  assign map_c  = (state == S_MAPY) ? coef_12 : coef_02;

  assign d_bot = $signed({1'b0, pix[1]}) - $signed({1'b0, pix[0]});
  assign d_top = $signed({1'b0, pix[3]}) - $signed({1'b0, pix[2]});
  assign d_fin = $signed({1'b0, acc[FRAC_W +: PIX_W]}) - $signed({1'b0, bottom});

  assign pix_sel = step[1:0] - 2'd1;

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (in_fire && in_ch.func == FUNC_READ) begin
          state_next = S_MAPX;
          step_next  = '0;
        end
      end
      S_MAPX: begin
        if (step == MAP_LAST) begin
          state_next = S_MAPY;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_MAPY: begin
        if (step == MAP_LAST) begin
          state_next = S_CHECK;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_CHECK: begin
        state_next = stop_now ? S_RESULT : S_FETCH;
        step_next  = '0;
      end
      S_FETCH: begin
        if (step == FETCH_LAST) begin
          state_next = S_BLEND;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_BLEND: begin
        if (step == BLEND_LAST) begin
          state_next = S_RESULT;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = (state == S_IDLE);
    mac_op      = '0;
    mac_a       = u;
    mac_b       = $signed({1'b0, map_a0[FRAC_W-1:0]});
    mac_base    = $signed({{(ACC_W-CFG_W-FRAC_W){map_c[CFG_W-1]}}, map_c, {FRAC_W{1'b0}}});
    mem_addr    = {in_ch.row[ROW_W-1:0], in_ch.col[COL_W-1:0]};
    mem_we      = in_fire && in_ch.func == FUNC_WRITE && row_ok && col_ok;
    case (state)
      S_MAPX, S_MAPY: begin
        mac_op.en = 1'b1;
        case (step[1:0])
          2'd0: begin
            mac_op.load = 1'b1;
          end
          2'd1: begin
            mac_b          = $signed({map_a0[CFG_W-1], map_a0[CFG_W-1:FRAC_W]});
            mac_op.shift16 = 1'b1;
          end
          2'd2: begin
            mac_a = v;
            mac_b = $signed({1'b0, map_a1[FRAC_W-1:0]});
          end
          default: begin
            mac_a          = v;
            mac_b          = $signed({map_a1[CFG_W-1], map_a1[CFG_W-1:FRAC_W]});
            mac_op.shift16 = 1'b1;
          end
        endcase
      end
      S_FETCH: begin
        case (step)
          3'd0: mem_addr = {x_idx, y_idx};
          3'd1: mem_addr = {x_idx + ROW_W'(1), y_idx};
          3'd2: mem_addr = {x_idx, y_idx + COL_W'(1)};
          default: mem_addr = {x_idx + ROW_W'(1), y_idx + COL_W'(1)};
        endcase
      end
      S_BLEND: begin
        case (step)
          3'd0: begin
            mac_op.en   = 1'b1;
            mac_op.load = 1'b1;
            mac_a       = $signed({{(OPA_W-DIFF_W){d_bot[DIFF_W-1]}}, d_bot});
            mac_b       = $signed({1'b0, fx});
            mac_base    = $signed({{(ACC_W-PIX_W-FRAC_W){1'b0}}, pix[0], {FRAC_W{1'b0}}});
          end
          3'd1: begin
            mac_op.en   = 1'b1;
            mac_op.load = 1'b1;
            mac_a       = $signed({{(OPA_W-DIFF_W){d_top[DIFF_W-1]}}, d_top});
            mac_b       = $signed({1'b0, fx});
            mac_base    = $signed({{(ACC_W-PIX_W-FRAC_W){1'b0}}, pix[2], {FRAC_W{1'b0}}});
          end
          3'd2: begin
            mac_op.en   = 1'b1;
            mac_op.load = 1'b1;
            mac_a       = $signed({{(OPA_W-DIFF_W){d_fin[DIFF_W-1]}}, d_fin});
            mac_b       = $signed({1'b0, fy});
            mac_base    = $signed({{(ACC_W-PIX_W-FRAC_W){1'b0}}, bottom, {FRAC_W{1'b0}}});
          end
          default: begin
            mac_op = '0;
          end
        endcase
      end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      coef_00   <= COEF_ONE;
      coef_01   <= '0;
      coef_02   <= '0;
      coef_10   <= '0;
      coef_11   <= COEF_ONE;
      coef_12   <= '0;
      shift_x   <= '0;
      shift_y   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (aw_reg_t'(cfg.index))
          REG_COEF_00: coef_00 <= cfg.data;
          REG_COEF_01: coef_01 <= cfg.data;
          REG_COEF_02: coef_02 <= cfg.data;
          REG_COEF_10: coef_10 <= cfg.data;
          REG_COEF_11: coef_11 <= cfg.data;
          REG_COEF_12: coef_12 <= cfg.data;
          REG_SHIFT_X: shift_x <= cfg.data;
          REG_SHIFT_Y: shift_y <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.func == FUNC_READ) begin
      u <= u_next;
      v <= v_next;
    end
    if (state == S_MAPY && step == '0) begin
      x_neg  <= acc_neg;
      x_ge   <= acc_int >= INT_W'(SRC_ROWS);
      x_last <= acc_int >= INT_W'(SRC_ROWS - 1);
      x_idx  <= acc[2*FRAC_W +: ROW_W];
      fx     <= acc[2*FRAC_W-1:FRAC_W];
    end
    if (state == S_CHECK) begin
      y_idx   <= acc[2*FRAC_W +: COL_W];
      fy      <= acc[2*FRAC_W-1:FRAC_W];
      res_inb <= !(x_neg || x_ge || acc_neg || y_ge_now);
      res_pix <= '0;
    end
    if (state == S_FETCH && step != '0) begin
      pix[pix_sel] <= mem_rdata;
    end
    if (state == S_BLEND && step == 3'd1) begin
      bottom <= acc[FRAC_W +: PIX_W];
    end
    if (state == S_BLEND && step == BLEND_LAST) begin
      res_pix <= acc[FRAC_W +: PIX_W];
    end
    if (state == S_RESULT && out_free) begin
      out_pix <= res_pix;
      out_inb <= res_inb;
    end
  end

  `AW_ASSERT_NEXT(a_read_starts_map, in_fire && in_ch.func == FUNC_READ, state == S_MAPX && step == '0, "Accepted request did not start the mapping pass")
  `AW_ASSERT_NOW(a_outside_is_zero, out_ch.valid && !out_ch.in_bounds, out_ch.pixel_out == '0, "Result outside the image carries a nonzero pixel")
  `AW_ASSERT_NEXT(a_result_loads, state == S_RESULT && out_free, state == S_IDLE && out_valid, "Finished result was not loaded into the output register")
  `AW_ASSERT_NOW(a_fetch_in_range, state == S_FETCH, !(x_neg || x_ge || x_last), "Neighbor fetch started for a row outside the image")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for affine_warp_bilinear: a queue-fed driver, a stalling result
// monitor and a bit-exact model of the inverse affine map and bilinear blend.
// Depends on aw_pkg, the channel interfaces in aw_ifs.sv and the affine_warp_bilinear RTL.
module testbench;
  import aw_pkg::*;

  localparam int ROWS         = 256;
  localparam int COLS         = 256;
  localparam int RANDOM_WORDS = 1550;
  localparam int PHASES       = 12;
  localparam int SETTLE       = 40;
  localparam int IDLE_PCT     = 26;
  localparam int LIMIT_CYCLES = 400000;

  typedef logic signed [79:0] wide_t;

  typedef enum logic [1:0] {
    PT_OUTSIDE,
    PT_EDGE,
    PT_INSIDE
  } point_kind_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
  } warp_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             in_bounds;
  } warp_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_func   = FUNC_WRITE;
  logic [COORD_W-1:0]   in_row    = '0;
  logic [COORD_W-1:0]   in_col    = '0;
  logic [PIX_W-1:0]     in_pixel  = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  aw_in_if  in_ch();
  aw_out_if out_ch();
  aw_cfg_if cfg_ch();

  assign in_ch.valid    = in_valid;
  assign in_ch.func     = in_func;
  assign in_ch.row      = in_row;
  assign in_ch.col      = in_col;
  assign in_ch.pixel_in = in_pixel;
  assign out_ch.ready   = out_ready;
  assign cfg_ch.valid   = cfg_valid;
  assign cfg_ch.index   = cfg_index;
  assign cfg_ch.data    = cfg_data;

  affine_warp_bilinear #(
    .SRC_ROWS(ROWS),
    .SRC_COLS(COLS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg   (cfg_ch)
  );

  logic [CFG_W-1:0] warp_reg [8];
  logic [CFG_W-1:0] next_cfg [8];
  logic [PIX_W-1:0] src_copy [ROWS*COLS];
  bit               planned  [ROWS*COLS];
  warp_word_t       pending_words[$];
  warp_result_t     expected_pixels[$];
  bit               in_fire      = 1'b0;
  bit               calm         = 1'b0;
  int               fail_count   = 0;
  int               cycles       = 0;
  int               words_issued = 0;
  int               win_row      = 0;
  int               win_col      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void map_point(input logic [COORD_W-1:0] row, col,
                                    output wide_t xq, yq);
    wide_t u, v;
    u = (wide_t'(row) <<< FRAC_W) - wide_t'($signed(warp_reg[REG_SHIFT_Y]));
    v = (wide_t'(col) <<< FRAC_W) - wide_t'($signed(warp_reg[REG_SHIFT_X]));
    xq = ((wide_t'($signed(warp_reg[REG_COEF_00])) * u
         + wide_t'($signed(warp_reg[REG_COEF_01])) * v) >>> FRAC_W)
         + wide_t'($signed(warp_reg[REG_COEF_02]));
    yq = ((wide_t'($signed(warp_reg[REG_COEF_10])) * u
         + wide_t'($signed(warp_reg[REG_COEF_11])) * v) >>> FRAC_W)
         + wide_t'($signed(warp_reg[REG_COEF_12]));
  endfunction

  function automatic point_kind_t classify(input wide_t xq, yq, output int x1, y1);
    wide_t xi, yi;
    x1 = 0;
    y1 = 0;
    if (xq < 0 || yq < 0) return PT_OUTSIDE;
    xi = xq >>> FRAC_W;
    yi = yq >>> FRAC_W;
    if (xi >= ROWS || yi >= COLS) return PT_OUTSIDE;
    x1 = int'(xi);
    y1 = int'(yi);
    if (x1 + 1 >= ROWS || y1 + 1 >= COLS) return PT_EDGE;
    return PT_INSIDE;
  endfunction

  function automatic warp_result_t warp_pixel(input logic [COORD_W-1:0] row, col);
    wide_t        xq, yq;
    int           x1, y1;
    int unsigned  fx, fy, lo, hi;
    point_kind_t  kind;
    warp_result_t res;
    map_point(row, col, xq, yq);
    kind = classify(xq, yq, x1, y1);
    res.pixel_out = '0;
    res.in_bounds = (kind != PT_OUTSIDE);
    if (kind == PT_INSIDE) begin
      fx = xq[15:0];
      fy = yq[15:0];
      lo = (src_copy[x1*COLS + y1] * (32'd65536 - fx)
           + src_copy[(x1+1)*COLS + y1] * fx) >> 16;
      hi = (src_copy[x1*COLS + y1 + 1] * (32'd65536 - fx)
           + src_copy[(x1+1)*COLS + y1 + 1] * fx) >> 16;
      res.pixel_out = 8'((lo * (32'd65536 - fy) + hi * fy) >> 16);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ch.ready;
    if (in_fire) begin
      if (in_func == FUNC_WRITE) begin
        if (in_row < ROWS && in_col < COLS) src_copy[in_row*COLS + in_col] = in_pixel;
      end else begin
        expected_pixels.push_back(warp_pixel(in_row, in_col));
      end
    end
  end

  always @(negedge clk) begin
    warp_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_func  <= w.func;
        in_row   <= w.row;
        in_col   <= w.col;
        in_pixel <= w.pixel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    warp_result_t want;
    if (!rst && out_ch.valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result word: pixel_out=%0d in_bounds=%0d",
               out_ch.pixel_out, out_ch.in_bounds);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel_out !== want.pixel_out) begin
          $error("pixel_out mismatch: expected %0d, actual %0d",
                 want.pixel_out, out_ch.pixel_out);
          fail_count++;
        end
        if (out_ch.in_bounds !== want.in_bounds) begin
          $error("in_bounds mismatch: expected %0d, actual %0d",
                 want.in_bounds, out_ch.in_bounds);
          fail_count++;
        end
      end
    end
  end

  function automatic void push_write(input int row, input int col, input logic [7:0] px);
    warp_word_t w;
    w.func  = FUNC_WRITE;
    w.row   = row[COORD_W-1:0];
    w.col   = col[COORD_W-1:0];
    w.pixel = px;
    pending_words.push_back(w);
    words_issued++;
    if (row < ROWS && col < COLS) planned[row*COLS + col] = 1'b1;
  endfunction

  // Every neighbor that a blended request reads is written first.
  function automatic void push_request(input int row, input int col);
    wide_t      xq, yq;
    int         x1, y1;
    warp_word_t w;
    map_point(row[COORD_W-1:0], col[COORD_W-1:0], xq, yq);
    if (classify(xq, yq, x1, y1) == PT_INSIDE) begin
      for (int dx = 0; dx < 2; dx++)
        for (int dy = 0; dy < 2; dy++)
          if (!planned[(x1+dx)*COLS + y1 + dy]) push_write(x1 + dx, y1 + dy, 8'($urandom()));
    end
    w.func  = FUNC_READ;
    w.row   = row[COORD_W-1:0];
    w.col   = col[COORD_W-1:0];
    w.pixel = 8'($urandom());
    pending_words.push_back(w);
    words_issued++;
  endfunction

  function automatic int pick_coord(input int base);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom_range(1023);
    if (pick < 16) return $urandom_range(235, 275);
    return base + $urandom_range(15);
  endfunction

  function automatic logic [CFG_W-1:0] edge_value();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void fill_words(input int count);
    int    stop, pick, x1, y1;
    wide_t xq, yq;
    stop = words_issued + count;
    while (words_issued < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_request(pick_coord(win_row), pick_coord(win_col));
      end else if (pick < 88) begin
        map_point(10'(pick_coord(win_row)), 10'(pick_coord(win_col)), xq, yq);
        if (classify(xq, yq, x1, y1) != PT_OUTSIDE) push_write(x1, y1, 8'($urandom()));
        else push_write($urandom_range(ROWS-1), $urandom_range(COLS-1), 8'($urandom()));
      end else begin
        push_write($urandom_range(1023), $urandom_range(1023), 8'($urandom()));
      end
    end
  endfunction

  task automatic apply_warp();
    for (int i = REG_COEF_00; i <= REG_SHIFT_Y; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= aw_reg_t'(i);
      cfg_data  <= next_cfg[i];
      do @(posedge clk); while (!cfg_ch.ready);
      warp_reg[i] = next_cfg[i];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic void identity_cfg();
    next_cfg[REG_COEF_00] = COEF_ONE;
    next_cfg[REG_COEF_01] = '0;
    next_cfg[REG_COEF_02] = '0;
    next_cfg[REG_COEF_10] = '0;
    next_cfg[REG_COEF_11] = COEF_ONE;
    next_cfg[REG_COEF_12] = '0;
    next_cfg[REG_SHIFT_X] = '0;
    next_cfg[REG_SHIFT_Y] = '0;
  endfunction

  initial begin
    int per_phase;
    per_phase = RANDOM_WORDS / PHASES;
    identity_cfg();
    warp_reg = next_cfg;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Ignored writes outside the image, pixel extremes, and requests that map
    // outside, onto the last row or column, and fully inside.
    push_write(1023, 1023, 8'hFF);
    push_write(ROWS, 5, 8'hAA);
    push_write(5, COLS, 8'h55);
    push_write(0, 0, 8'h00);
    push_write(0, 1, 8'hFF);
    push_write(1, 0, 8'hFF);
    push_write(1, 1, 8'h00);
    push_request(0, 0);
    push_request(1023, 1023);
    push_request(ROWS, 0);
    push_request(0, COLS);
    push_request(ROWS - 1, COLS - 1);
    push_request(ROWS - 1, 0);
    push_request(0, COLS - 1);
    push_request(ROWS - 2, COLS - 2);
    drain();

    next_cfg[REG_SHIFT_X] = 32'hFFFF_8000;
    next_cfg[REG_SHIFT_Y] = 32'hFFFF_C000;
    apply_warp();
    push_request(0, 0);
    push_request(10, 20);
    push_request(ROWS - 2, COLS - 2);
    push_request(ROWS - 1, 0);
    push_request(0, COLS - 1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      win_row = $urandom_range(60);
      win_col = $urandom_range(60);
      if (p % 4 == 0) begin
        identity_cfg();
        win_row = $urandom_range(240);
        win_col = $urandom_range(240);
        next_cfg[REG_SHIFT_X] = $urandom_range(0, 16 << 16) - (8 << 16);
        next_cfg[REG_SHIFT_Y] = $urandom_range(0, 16 << 16) - (8 << 16);
      end else if (p == 3) begin
        foreach (next_cfg[i]) next_cfg[i] = 32'h7FFF_FFFF;
      end else if (p == 7) begin
        foreach (next_cfg[i]) next_cfg[i] = 32'h8000_0000;
      end else if (p == 11) begin
        foreach (next_cfg[i]) next_cfg[i] = $urandom();
        next_cfg[REG_COEF_00] = '0;
        next_cfg[REG_COEF_01] = '0;
        next_cfg[REG_COEF_10] = '0;
        next_cfg[REG_COEF_11] = '0;
        next_cfg[REG_COEF_02] = $urandom_range(0, (ROWS << 16) - 1);
        next_cfg[REG_COEF_12] = $urandom_range(0, (COLS << 16) - 1);
      end else begin
        next_cfg[REG_COEF_00] = $urandom_range(32768, 98304);
        next_cfg[REG_COEF_01] = $urandom_range(0, 39320) - 19660;
        next_cfg[REG_COEF_02] = $urandom_range(0, 230 << 16);
        next_cfg[REG_COEF_10] = $urandom_range(0, 39320) - 19660;
        next_cfg[REG_COEF_11] = $urandom_range(32768, 98304);
        next_cfg[REG_COEF_12] = $urandom_range(0, 230 << 16);
        next_cfg[REG_SHIFT_X] = $urandom_range(0, 16 << 16) - (8 << 16);
        next_cfg[REG_SHIFT_Y] = $urandom_range(0, 16 << 16) - (8 << 16);
        foreach (next_cfg[i]) if ($urandom_range(9) == 0) next_cfg[i] = edge_value();
      end
      calm = (p == 5);
      apply_warp();
      if (p == 2) begin
        fill_words(per_phase / 2);
        drain();
        fill_words(per_phase - per_phase / 2);
      end else begin
        fill_words(per_phase);
      end
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aw_pkg.sv
rtl/aw_ifs.sv
rtl/aw_mac.sv
rtl/aw_img_mem.sv
rtl/affine_warp_bilinear.sv
verif/testbench.sv
